FILE: design/tcl_pkg.sv
// Shared types, command codes and constants of the text-mode cell line renderer.
// Used by every module in the design folder; depends on nothing else.
package tcl_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_DRAW  = 2'd2;

  localparam logic [1:0] CFG_PAGE_SELECT = 2'd0;
  localparam logic [1:0] CFG_FB_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_FB_HEIGHT   = 2'd2;

  localparam int GLYPH_COUNT = 64;
  localparam int STORE_AW    = 9;
  localparam int CFG_DW      = 12;

  localparam logic [15:0] TEXT_PAGE0_BASE  = 16'h0400;
  localparam logic [15:0] TEXT_PAGE1_BASE  = 16'h0800;
  localparam logic [15:0] ROW_GROUP_STRIDE = 16'd40;
  localparam logic [9:0]  CELL_PIXEL_WIDTH = 10'd14;

  localparam logic [6:0] GLYPH_FIRST_CODE = 7'h20;
  localparam logic [6:0] GLYPH_LAST_CODE  = 7'h5F;

  localparam logic [11:0] FB_WIDTH_RESET  = 12'd560;
  localparam logic [11:0] FB_HEIGHT_RESET = 12'd384;

  // Cell data held between the decode stage and the pixel stage.
  typedef struct packed {
    logic [15:0] cell_address;
    logic [9:0]  fb_x;
    logic [9:0]  fb_y;
    logic        invert;
  } cell_info_t;

endpackage

FILE: design/text_mode_cell_line_renderer.sv
// Top level of the text-mode cell line renderer: configuration registers,
// frame counter, request handshake and the decode, glyph store and pixel stages.
// Depends on tcl_pkg, tcl_glyph_ram, tcl_decode and tcl_pixel.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per accepted
//   cycle. A load request writes one byte of the 512-byte glyph store; a frame
//   request advances the 5-bit frame counter (flash is on while its bit 4 is
//   clear); a draw request produces exactly one result on the output channel
//   (out_valid/out_ready). Command code 3 is accepted and dropped.
//   A draw accepted at an edge fills the decode stage and reads the glyph
//   store at that edge, moves on to the pixel/clip register once that
//   register is free and is shown on out_* from then on, where the receiver
//   can take it.
//   Throughput: one request per unstalled cycle, set by the single glyph store
//   read port and the two-stage pipeline; load and frame requests take effect
//   as they are accepted, so a draw right behind a load sees the new byte.
//   Stall: when out_ready is low a full result register holds; the decode stage
//   still takes one more draw, and in_ready drops only when both are full.
//   Reset (rst_n low, synchronous) empties both stages, clears the frame
//   counter and restores page 0, width 560 and height 384. The glyph store
//   has no reset and must be loaded before the glyphs it holds are drawn.
//   The cfg_* port writes a register on any cycle with cfg_we high; it is
//   meant to be used only while no draw is in flight.
module text_mode_cell_line_renderer
  import tcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [8:0]        in_glyph_addr,
  input  logic [7:0]        in_glyph_data,
  input  logic [4:0]        in_text_row,
  input  logic [5:0]        in_text_col,
  input  logic [2:0]        in_cell_line,
  input  logic [7:0]        in_char_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_cell_address,
  output logic [13:0]       out_pixels,
  output logic [9:0]        out_fb_x,
  output logic [9:0]        out_fb_y,
  output logic [13:0]       out_column_visible,
  output logic [1:0]        out_rows_visible
);

  logic              page_select_r;
  logic [CFG_DW-1:0] fb_width_r;
  logic [CFG_DW-1:0] fb_height_r;
  logic [4:0]        frame_cnt_r;
  logic [4:0]        frame_cnt_nxt;

  logic                in_accept;
  logic                draw_accept;
  logic                load_accept;
  logic                frame_accept;
  logic                s1_valid;
  cell_info_t          s1_info;
  logic [STORE_AW-1:0] glyph_rd_addr;
  logic [7:0]          glyph_line;
  logic                out_free;

  // The decode stage can take a request when it is empty or is moving on.
  assign in_ready     = !s1_valid || out_free;
  assign in_accept    = in_valid && in_ready;
  assign draw_accept  = in_accept && (in_command == CMD_DRAW);
  assign load_accept  = in_accept && (in_command == CMD_LOAD);
  assign frame_accept = in_accept && (in_command == CMD_FRAME);

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_select_r <= 1'b0;
      fb_width_r    <= FB_WIDTH_RESET;
      fb_height_r   <= FB_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_SELECT: page_select_r <= cfg_data[0];
        CFG_FB_WIDTH:    fb_width_r    <= cfg_data;
        CFG_FB_HEIGHT:   fb_height_r   <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Frame counter wraps naturally at 32.
  assign frame_cnt_nxt = frame_accept ? frame_cnt_r + 5'd1 : frame_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= 5'd0;
    end else begin
      frame_cnt_r <= frame_cnt_nxt;
    end
  end

  tcl_glyph_ram u_glyph_ram (
    .clk     (clk),
    .wr_en   (load_accept),
    .wr_addr (in_glyph_addr),
    .wr_data (in_glyph_data),
    .rd_en   (draw_accept),
    .rd_addr (glyph_rd_addr),
    .rd_data (glyph_line)
  );

  // The flash phase is sampled when the draw is accepted, so later frame
  // requests cannot change a draw already in the pipeline.
  tcl_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (draw_accept),
    .drain         (out_free),
    .page_select   (page_select_r),
    .flash_on      (!frame_cnt_r[4]),
    .text_row      (in_text_row),
    .text_col      (in_text_col),
    .cell_line     (in_cell_line),
    .char_code     (in_char_code),
    .glyph_rd_addr (glyph_rd_addr),
    .s1_valid      (s1_valid),
    .s1_info       (s1_info)
  );

  tcl_pixel u_pixel (
    .clk                (clk),
    .rst_n              (rst_n),
    .s1_valid           (s1_valid),
    .s1_info            (s1_info),
    .glyph_line         (glyph_line),
    .fb_width           (fb_width_r),
    .fb_height          (fb_height_r),
    .out_ready          (out_ready),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_cell_address   (out_cell_address),
    .out_pixels         (out_pixels),
    .out_fb_x           (out_fb_x),
    .out_fb_y           (out_fb_y),
    .out_column_visible (out_column_visible),
    .out_rows_visible   (out_rows_visible)
  );

  // A frame request advances the counter by exactly one, modulo 32.
  a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
    frame_accept |=> frame_cnt_r == $past(frame_cnt_r) + 5'd1)
    else $error("frame counter did not advance by one");

  // A stage-one cell that can move on always shows up as a result.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_free) |=> out_valid)
    else $error("decoded cell lost between stages");

  // Load and frame requests never occupy the decode stage.
  a_no_result_for_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_command != CMD_DRAW) && out_free) |=> !s1_valid)
    else $error("non-draw request entered the pipeline");

  // An accepted draw is held in the decode stage on the next cycle.
  a_draw_enters: assert property (@(posedge clk) disable iff (!rst_n)
    draw_accept |=> s1_valid)
    else $error("accepted draw missing from decode stage");

  // Reset restores the default framebuffer size.
  a_cfg_reset: assert property (@(posedge clk)
    !rst_n |=> (fb_width_r == FB_WIDTH_RESET) && (fb_height_r == FB_HEIGHT_RESET))
    else $error("framebuffer size not restored by reset");

endmodule

FILE: design/tcl_glyph_ram.sv
// Glyph store: 512 x 8 single-port-write, registered-read memory.
// Depends on tcl_pkg for the address width.
module tcl_glyph_ram
  import tcl_pkg::*;
(
  input  logic                clk,
  input  logic                wr_en,
  input  logic [STORE_AW-1:0] wr_addr,
  input  logic [7:0]          wr_data,
  input  logic                rd_en,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [2**STORE_AW];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while the pixel stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/tcl_decode.sv
// Decode stage: glyph selection, video address, coordinates and inverse flag.
// Depends on tcl_pkg for constants and the cell_info_t stage register type.
module tcl_decode
  import tcl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                drain,
  input  logic                page_select,
  input  logic                flash_on,
  input  logic [4:0]          text_row,
  input  logic [5:0]          text_col,
  input  logic [2:0]          cell_line,
  input  logic [7:0]          char_code,
  output logic [STORE_AW-1:0] glyph_rd_addr,
  output logic                s1_valid,
  output cell_info_t          s1_info
);

  logic [6:0]  glyph_idx;
  logic [6:0]  glyph_off;
  logic [5:0]  glyph_sel;
  logic        idx_in_range;
  logic [15:0] page_base;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  cell_info_t  s1_info_r;
  cell_info_t  s1_info_nxt;

  always_comb begin
    // Inverse and flash codes fold onto the low 64 codes; normal codes drop bit 7.
    glyph_idx    = char_code[7] ? char_code[6:0] : {1'b0, char_code[5:0]};
    glyph_off    = glyph_idx - GLYPH_FIRST_CODE;
    idx_in_range = (glyph_idx >= GLYPH_FIRST_CODE) && (glyph_idx <= GLYPH_LAST_CODE)
                   && ({3'b000, glyph_off[5:0]} < 9'(GLYPH_COUNT));
    glyph_sel    = idx_in_range ? glyph_off[5:0] : 6'd0;
    glyph_rd_addr = {glyph_sel, cell_line};

    page_base = page_select ? TEXT_PAGE1_BASE : TEXT_PAGE0_BASE;

    s1_info_nxt.cell_address = page_base
                               + {6'd0, text_row[2:0], 7'd0}
                               + 16'(ROW_GROUP_STRIDE * {14'd0, text_row[4:3]})
                               + {10'd0, text_col};
    s1_info_nxt.fb_x   = 10'({4'd0, text_col} * CELL_PIXEL_WIDTH);
    s1_info_nxt.fb_y   = {1'b0, text_row, cell_line, 1'b0};
    s1_info_nxt.invert = !char_code[7] && (!char_code[6] || flash_on);
  end

  always_comb begin
    priority if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (drain) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_info_r <= s1_info_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_info  = s1_info_r;

endmodule

FILE: design/tcl_pixel.sv
// Pixel stage: inversion, pixel doubling, clip masks and the result register.
// Depends on tcl_pkg for cell_info_t and the configuration width.
module tcl_pixel
  import tcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  cell_info_t        s1_info,
  input  logic [7:0]        glyph_line,
  input  logic [CFG_DW-1:0] fb_width,
  input  logic [CFG_DW-1:0] fb_height,
  input  logic              out_ready,
  output logic              out_free,
  output logic              out_valid,
  output logic [15:0]       out_cell_address,
  output logic [13:0]       out_pixels,
  output logic [9:0]        out_fb_x,
  output logic [9:0]        out_fb_y,
  output logic [13:0]       out_column_visible,
  output logic [1:0]        out_rows_visible
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        take;
  logic [6:0]  shown;
  logic [13:0] pixels_nxt;
  logic [13:0] colmask_nxt;
  logic [1:0]  rowmask_nxt;
  logic [15:0] cell_address_r;
  logic [13:0] pixels_r;
  logic [9:0]  fb_x_r;
  logic [9:0]  fb_y_r;
  logic [13:0] colmask_r;
  logic [1:0]  rowmask_r;

  assign out_free = !out_valid_r || out_ready;
  assign take     = s1_valid && out_free;

  always_comb begin
    // Bit 7 of a glyph line is never displayed.
    shown = s1_info.invert ? ~glyph_line[6:0] : glyph_line[6:0];
    for (int k = 0; k < 7; k++) begin
      pixels_nxt[2*k]   = shown[k];
      pixels_nxt[2*k+1] = shown[k];
    end
    for (int j = 0; j < 14; j++) begin
      colmask_nxt[j] = ({2'b00, s1_info.fb_x} + CFG_DW'(j)) < fb_width;
    end
    rowmask_nxt[0] = {2'b00, s1_info.fb_y} < fb_height;
    rowmask_nxt[1] = {2'b00, s1_info.fb_y[9:1], 1'b1} < fb_height;
  end

  always_comb begin
    priority if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_address_r <= s1_info.cell_address;
      pixels_r       <= pixels_nxt;
      fb_x_r         <= s1_info.fb_x;
      fb_y_r         <= s1_info.fb_y;
      colmask_r      <= colmask_nxt;
      rowmask_r      <= rowmask_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_address   = cell_address_r;
  assign out_pixels         = pixels_r;
  assign out_fb_x           = fb_x_r;
  assign out_fb_y           = fb_y_r;
  assign out_column_visible = colmask_r;
  assign out_rows_visible   = rowmask_r;

endmodule
